FILE: hw/rtl/sobol_sequence_generator_defines.svh
// Assertion macros shared by the generator's modules.
`ifndef SOBOL_SEQUENCE_GENERATOR_DEFINES_SVH
`define SOBOL_SEQUENCE_GENERATOR_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SSG_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SSG_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hw/rtl/ssg_pkg.sv
package ssg_pkg;

   localparam int POINT_W    = 32;
   localparam int CMD_W      = 2;
   localparam int DEG_W      = 5;
   localparam int INIT_W     = 18;
   localparam int POLY_W     = 17;
   localparam int BITS_W     = 6;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 17;

   localparam logic [CMD_W-1:0] CMD_LOAD    = 2'd0;
   localparam logic [CMD_W-1:0] CMD_RESTART = 2'd1;
   localparam logic [CMD_W-1:0] CMD_NEXT    = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_PLAIN  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DEGREE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_POLY   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BITS   = 2'd3;

   localparam logic [DEG_W-1:0]  DEGREE_RESET = 5'd1;
   localparam logic [BITS_W-1:0] BITS_RESET   = 6'd32;

   typedef struct packed {
      logic load;
      logic restart;
      logic next;
      logic entry;
      logic init_wr;
      logic first;
      logic step;
   } ssg_cmd_type;

   typedef struct packed {
      logic plain;
      logic in_init;
      logic last;
      logic s_one;
      logic k_last;
   } ssg_status_type;

endpackage

FILE: hw/rtl/sobol_sequence_generator.sv
// One dimension of a Sobol sequence in Gray-code order, as 0.32 fixed-point points. A next
// transaction is taken every cycle while the result register is free or being emptied; its
// result is registered and appears in the next cycle, and the direction entry it selects
// is read from the direction-table RAM and folded into the point in the following cycle,
// forwarded to a next transaction in that same cycle. A load transaction writes one initial
// direction number. A restart rebuilds all MAX_BITS table entries, one at a time, and no
// transaction is taken meanwhile: an entry is written in ENTRY for the first dimension,
// after ENTRY and INIT from an initial number, and after ENTRY, FIRST and any STEP states
// by the polynomial recurrence, bounded by one RAM read per cycle. Configuration writes
// are always ready and are meant only while the generator is idle.
module sobol_sequence_generator #(
   parameter int MAX_BITS   = 32,
   parameter int MAX_DEGREE = 18
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [ssg_pkg::CMD_W-1:0]      req_command,
   input  logic [ssg_pkg::DEG_W-1:0]      req_entry_index,
   input  logic [ssg_pkg::INIT_W-1:0]     req_initial_value,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [ssg_pkg::POINT_W-1:0]    rsp_point,
   output logic [ssg_pkg::POINT_W-1:0]    rsp_point_index,
   output logic                           rsp_exhausted,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [ssg_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [ssg_pkg::CSR_DATA_W-1:0] csr_wdata
);

   import ssg_pkg::*;

   ssg_cmd_type    cmd;
   ssg_status_type status;
   logic           csr_we;

   assign csr_ready = 1'b1;
   assign csr_we    = csr_valid && csr_ready;

   ssg_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_command (req_command),
      .req_stall   (req_stall),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .cmd         (cmd),
      .status      (status)
   );

   ssg_datapath #(
      .MAX_BITS   (MAX_BITS),
      .MAX_DEGREE (MAX_DEGREE)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_entry_index   (req_entry_index),
      .req_initial_value (req_initial_value),
      .cmd               (cmd),
      .status            (status),
      .rsp_point         (rsp_point),
      .rsp_point_index   (rsp_point_index),
      .rsp_exhausted     (rsp_exhausted)
   );

endmodule

FILE: hw/rtl/ssg_ram.sv
module ssg_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/ssg_ctrl.sv
`include "sobol_sequence_generator_defines.svh"

module ssg_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic [ssg_pkg::CMD_W-1:0]   req_command,
   output logic                        req_stall,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output ssg_pkg::ssg_cmd_type        cmd,
   input  ssg_pkg::ssg_status_type     status
);

   import ssg_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_ENTRY = 5'b00010,
      ST_INIT  = 5'b00100,
      ST_FIRST = 5'b01000,
      ST_STEP  = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      req_acc;
   logic      entry_done;

   assign req_stall = (state_ff != ST_IDLE) ||
                      ((req_command == CMD_NEXT) && rsp_valid_ff && rsp_stall);
   assign req_acc   = req_valid && !req_stall;

   always_comb begin
      cmd         = '0;
      cmd.load    = req_acc && (req_command == CMD_LOAD);
      cmd.restart = req_acc && (req_command == CMD_RESTART);
      cmd.next    = req_acc && (req_command == CMD_NEXT);
      cmd.entry   = (state_ff == ST_ENTRY);
      cmd.init_wr = (state_ff == ST_INIT);
      cmd.first   = (state_ff == ST_FIRST);
      cmd.step    = (state_ff == ST_STEP);
   end

   assign entry_done = status.last;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd.restart) begin
               state_in = ST_ENTRY;
            end
         end
         ST_ENTRY: begin
            if (status.plain) begin
               state_in = entry_done ? ST_IDLE : ST_ENTRY;
            end else if (status.in_init) begin
               state_in = ST_INIT;
            end else begin
               state_in = ST_FIRST;
            end
         end
         ST_INIT: begin
            state_in = entry_done ? ST_IDLE : ST_ENTRY;
         end
         ST_FIRST: begin
            if (status.s_one) begin
               state_in = entry_done ? ST_IDLE : ST_ENTRY;
            end else begin
               state_in = ST_STEP;
            end
         end
         ST_STEP: begin
            if (status.k_last) begin
               state_in = entry_done ? ST_IDLE : ST_ENTRY;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.next) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   `SSG_ASSERT_NEXT(a_restart_starts_build, clock, reset, cmd.restart, state_ff == ST_ENTRY, "Restart did not start the table build.")
   `SSG_ASSERT_NEXT(a_next_gives_result, clock, reset, cmd.next, rsp_valid_ff, "Next transaction produced no result.")
   `SSG_ASSERT_IMPL(a_no_cmd_in_build, clock, reset, state_ff != ST_IDLE, !cmd.load && !cmd.restart && !cmd.next, "Transaction accepted during the table build.")

endmodule

FILE: hw/rtl/ssg_datapath.sv
`include "sobol_sequence_generator_defines.svh"

module ssg_datapath #(
   parameter int MAX_BITS   = 32,
   parameter int MAX_DEGREE = 18
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [ssg_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [ssg_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  logic [ssg_pkg::DEG_W-1:0]        req_entry_index,
   input  logic [ssg_pkg::INIT_W-1:0]       req_initial_value,
   input  ssg_pkg::ssg_cmd_type             cmd,
   output ssg_pkg::ssg_status_type          status,
   output logic [ssg_pkg::POINT_W-1:0]      rsp_point,
   output logic [ssg_pkg::POINT_W-1:0]      rsp_point_index,
   output logic                             rsp_exhausted
);

   import ssg_pkg::*;

   localparam int ADDR_W  = $clog2(MAX_BITS);
   localparam int INIT_AW = $clog2(MAX_DEGREE);
   localparam int CNT_W   = MAX_BITS + 1;
   localparam int P_W     = $clog2(MAX_BITS + 1);

   logic                plain_ff;
   logic [DEG_W-1:0]    degree_ff;
   logic [POLY_W-1:0]   poly_ff;
   logic [BITS_W-1:0]   bits_ff;

   logic [DEG_W-1:0]    s_eff;
   logic [BITS_W-1:0]   l_eff;

   logic [ADDR_W-1:0]   e_ff, e_in;
   logic [DEG_W-1:0]    k_ff, k_in;
   logic [POINT_W-1:0]  acc_ff, acc_in;
   logic [POINT_W-1:0]  point_ff, point_in, point_cur;
   logic [CNT_W-1:0]    cnt_ff, cnt_in, cnt_inc, low_zero, limit;
   logic                pend_ff, pend_in;
   logic [P_W-1:0]      p;
   logic                exh;
   logic                coef_bit;

   logic [POINT_W-1:0]  rsp_point_ff;
   logic [POINT_W-1:0]  rsp_index_ff;
   logic                rsp_exh_ff;

   logic                dir_we;
   logic [ADDR_W-1:0]   dir_raddr;
   logic [POINT_W-1:0]  dir_wdata, dir_rdata;
   logic                init_we;
   logic [INIT_AW-1:0]  init_waddr, init_raddr;
   logic [INIT_W-1:0]   init_rdata;
   logic [POINT_W-1:0]  plain_val, init_val;

   always_ff @(posedge clock) begin
      if (reset) begin
         plain_ff  <= 1'b1;
         degree_ff <= DEGREE_RESET;
         poly_ff   <= '0;
         bits_ff   <= BITS_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_PLAIN:  plain_ff  <= csr_wdata[0];
            CSR_DEGREE: degree_ff <= csr_wdata[DEG_W-1:0];
            CSR_POLY:   poly_ff   <= csr_wdata[POLY_W-1:0];
            CSR_BITS:   bits_ff   <= csr_wdata[BITS_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      if (degree_ff == '0) begin
         s_eff = DEG_W'(1);
      end else if (degree_ff > DEG_W'(MAX_DEGREE)) begin
         s_eff = DEG_W'(MAX_DEGREE);
      end else begin
         s_eff = degree_ff;
      end
      if (bits_ff == '0) begin
         l_eff = BITS_W'(1);
      end else if (bits_ff > BITS_W'(MAX_BITS)) begin
         l_eff = BITS_W'(MAX_BITS);
      end else begin
         l_eff = bits_ff;
      end
   end

   assign status.plain   = plain_ff;
   assign status.in_init = (6'(e_ff) < 6'(s_eff));
   assign status.last    = (e_ff == ADDR_W'(MAX_BITS - 1));
   assign status.s_one   = (s_eff == DEG_W'(1));
   assign status.k_last  = (k_ff == (s_eff - DEG_W'(1)));

   // Lowest clear bit of the counter marks the direction entry for this point.
   assign cnt_inc  = cnt_ff + CNT_W'(1);
   assign low_zero = cnt_inc & ~cnt_ff;

   always_comb begin
      p = '0;
      for (int b = 0; b < CNT_W; b++) begin
         if (low_zero[b]) begin
            p = p | P_W'(b);
         end
      end
   end

   assign limit = CNT_W'(1) << l_eff;
   assign exh   = (cnt_ff >= limit);

   assign point_cur = pend_ff ? (point_ff ^ dir_rdata) : point_ff;
   assign point_in  = cmd.restart ? '0 : point_cur;
   assign pend_in   = cmd.next && !exh && (6'(p) < l_eff);

   always_comb begin
      cnt_in = cnt_ff;
      if (cmd.restart) begin
         cnt_in = '0;
      end else if (cmd.next && !exh) begin
         cnt_in = cnt_inc;
      end
   end

   assign coef_bit  = poly_ff[5'(s_eff - DEG_W'(1) - k_ff)];
   assign plain_val = {1'b1, {(POINT_W - 1){1'b0}}} >> e_ff;
   assign init_val  = POINT_W'(init_rdata) << (5'd31 - 5'(e_ff));

   always_comb begin
      if (cmd.first) begin
         acc_in = dir_rdata ^ (dir_rdata >> s_eff);
      end else if (cmd.step && coef_bit) begin
         acc_in = acc_ff ^ dir_rdata;
      end else begin
         acc_in = acc_ff;
      end
   end

   always_comb begin
      k_in = k_ff;
      if (cmd.first) begin
         k_in = DEG_W'(1);
      end else if (cmd.step) begin
         k_in = k_ff + DEG_W'(1);
      end
   end

   assign dir_we = (cmd.entry && plain_ff) || cmd.init_wr ||
                   (cmd.first && status.s_one) || (cmd.step && status.k_last);

   always_comb begin
      if (cmd.entry && plain_ff) begin
         dir_wdata = plain_val;
      end else if (cmd.init_wr) begin
         dir_wdata = init_val;
      end else begin
         dir_wdata = acc_in;
      end
   end

   always_comb begin
      if (cmd.next) begin
         dir_raddr = ADDR_W'(p);
      end else if (cmd.entry) begin
         dir_raddr = e_ff - ADDR_W'(s_eff);
      end else if (cmd.first) begin
         dir_raddr = e_ff - ADDR_W'(1);
      end else begin
         dir_raddr = e_ff - ADDR_W'(k_ff) - ADDR_W'(1);
      end
   end

   always_comb begin
      e_in = e_ff;
      if (cmd.restart) begin
         e_in = '0;
      end else if (dir_we && !status.last) begin
         e_in = e_ff + ADDR_W'(1);
      end
   end

   assign init_we    = cmd.load && (req_entry_index != '0) &&
                       (req_entry_index <= DEG_W'(MAX_DEGREE));
   assign init_waddr = INIT_AW'(req_entry_index - DEG_W'(1));
   assign init_raddr = INIT_AW'(e_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         e_ff     <= '0;
         cnt_ff   <= '0;
         point_ff <= '0;
         pend_ff  <= 1'b0;
      end else begin
         e_ff     <= e_in;
         cnt_ff   <= cnt_in;
         point_ff <= point_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff   <= k_in;
      acc_ff <= acc_in;
      if (cmd.next) begin
         rsp_point_ff <= point_cur;
         rsp_index_ff <= exh ? POINT_W'(limit - CNT_W'(1)) : POINT_W'(cnt_ff);
         rsp_exh_ff   <= exh;
      end
   end

   assign rsp_point       = rsp_point_ff;
   assign rsp_point_index = rsp_index_ff;
   assign rsp_exhausted   = rsp_exh_ff;

   ssg_ram #(
      .WIDTH (POINT_W),
      .DEPTH (MAX_BITS)
   ) u_dir_ram (
      .clock   (clock),
      .wr_en   (dir_we),
      .wr_addr (e_ff),
      .wr_data (dir_wdata),
      .rd_addr (dir_raddr),
      .rd_data (dir_rdata)
   );

   ssg_ram #(
      .WIDTH (INIT_W),
      .DEPTH (MAX_DEGREE)
   ) u_init_ram (
      .clock   (clock),
      .wr_en   (init_we),
      .wr_addr (init_waddr),
      .wr_data (req_initial_value),
      .rd_addr (init_raddr),
      .rd_data (init_rdata)
   );

   `SSG_ASSERT_IMPL(a_entry_in_range, clock, reset, 1'b1, e_ff <= ADDR_W'(MAX_BITS - 1), "Build entry index beyond the table.")
   `SSG_ASSERT_IMPL(a_pend_cause, clock, reset, pend_ff, $past(cmd.next && !exh), "Point update pending without a live next transaction.")
   `SSG_ASSERT_NEXT(a_exh_holds_count, clock, reset, cmd.next && exh, $stable(cnt_ff) && !pend_ff, "Exhausted generator changed its state.")

endmodule
